// ===== design/mlhd_pkg.sv =====
// Package for the MPEG-1 layer III header decoder: status codes, header
// field codes, stage record types and the constant rate and length tables.
// No dependencies.
package mlhd_pkg;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_NO_SYNC     = 4'd1,
        ST_NOT_MPEG1   = 4'd2,
        ST_LAYER_I     = 4'd3,
        ST_LAYER_II    = 4'd4,
        ST_LAYER_RSVD  = 4'd5,
        ST_CRC         = 4'd6,
        ST_BAD_BITRATE = 4'd7,
        ST_RSVD_RATE   = 4'd8
    } status_t;

    localparam logic [10:0] SYNC_CODE     = 11'h7FF;
    localparam logic [1:0]  VERSION_MPEG1 = 2'b11;
    localparam logic [1:0]  LAYER_CODE_I  = 2'b11;
    localparam logic [1:0]  LAYER_CODE_II = 2'b10;
    localparam logic [1:0]  LAYER_CODE_III = 2'b01;
    localparam logic [3:0]  BR_IDX_BAD    = 4'd15;
    localparam logic [1:0]  SR_IDX_RSVD   = 2'd3;
    localparam logic [1:0]  MODE_JOINT    = 2'd1;

    localparam int HDR_W  = 32;
    localparam int RES_W  = 56;

    typedef struct packed {
        status_t     status;
        logic [3:0]  br_idx;
        logic [1:0]  sr_idx;
        logic        pad;
        logic [1:0]  mode;
        logic        ms;
        logic        is;
        logic        copy;
        logic        orig;
        logic [1:0]  emph;
    } hdr_fields_t;

    typedef struct packed {
        status_t     status;
        logic [8:0]  kbps;
        logic [15:0] rate;
        logic [10:0] base_len;
        logic        pad;
        logic [1:0]  mode;
        logic        ms;
        logic        is;
        logic        copy;
        logic        orig;
        logic [1:0]  emph;
    } hdr_lookup_t;

    typedef struct packed {
        status_t     status;
        logic [10:0] frame_length;
        logic [8:0]  bitrate_kbps;
        logic [15:0] sample_rate_hz;
        logic        padded;
        logic [1:0]  channel_mode;
        logic        intensity_stereo;
        logic        mid_side_stereo;
        logic        copyright_flag;
        logic        original_flag;
        logic [1:0]  emphasis;
    } hdr_result_t;

    function automatic logic [8:0] kbps_lookup(input logic [3:0] idx);
        logic [8:0] v;
        unique case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd32;
            4'd2:    v = 9'd40;
            4'd3:    v = 9'd48;
            4'd4:    v = 9'd56;
            4'd5:    v = 9'd64;
            4'd6:    v = 9'd80;
            4'd7:    v = 9'd96;
            4'd8:    v = 9'd112;
            4'd9:    v = 9'd128;
            4'd10:   v = 9'd160;
            4'd11:   v = 9'd192;
            4'd12:   v = 9'd224;
            4'd13:   v = 9'd256;
            4'd14:   v = 9'd320;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rate_lookup(input logic [1:0] idx);
        logic [15:0] v;
        unique case (idx)
            2'd0:    v = 16'd44100;
            2'd1:    v = 16'd48000;
            2'd2:    v = 16'd32000;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // floor(144000 * kbps / rate) for every legal pair of indices.
    function automatic logic [10:0] len_lookup(input logic [3:0] br, input logic [1:0] sr);
        logic [10:0] v;
        unique case ({sr, br})
            {2'd0, 4'd1}:  v = 11'd104;
            {2'd0, 4'd2}:  v = 11'd130;
            {2'd0, 4'd3}:  v = 11'd156;
            {2'd0, 4'd4}:  v = 11'd182;
            {2'd0, 4'd5}:  v = 11'd208;
            {2'd0, 4'd6}:  v = 11'd261;
            {2'd0, 4'd7}:  v = 11'd313;
            {2'd0, 4'd8}:  v = 11'd365;
            {2'd0, 4'd9}:  v = 11'd417;
            {2'd0, 4'd10}: v = 11'd522;
            {2'd0, 4'd11}: v = 11'd626;
            {2'd0, 4'd12}: v = 11'd731;
            {2'd0, 4'd13}: v = 11'd835;
            {2'd0, 4'd14}: v = 11'd1044;
            {2'd1, 4'd1}:  v = 11'd96;
            {2'd1, 4'd2}:  v = 11'd120;
            {2'd1, 4'd3}:  v = 11'd144;
            {2'd1, 4'd4}:  v = 11'd168;
            {2'd1, 4'd5}:  v = 11'd192;
            {2'd1, 4'd6}:  v = 11'd240;
            {2'd1, 4'd7}:  v = 11'd288;
            {2'd1, 4'd8}:  v = 11'd336;
            {2'd1, 4'd9}:  v = 11'd384;
            {2'd1, 4'd10}: v = 11'd480;
            {2'd1, 4'd11}: v = 11'd576;
            {2'd1, 4'd12}: v = 11'd672;
            {2'd1, 4'd13}: v = 11'd768;
            {2'd1, 4'd14}: v = 11'd960;
            {2'd2, 4'd1}:  v = 11'd144;
            {2'd2, 4'd2}:  v = 11'd180;
            {2'd2, 4'd3}:  v = 11'd216;
            {2'd2, 4'd4}:  v = 11'd252;
            {2'd2, 4'd5}:  v = 11'd288;
            {2'd2, 4'd6}:  v = 11'd360;
            {2'd2, 4'd7}:  v = 11'd432;
            {2'd2, 4'd8}:  v = 11'd504;
            {2'd2, 4'd9}:  v = 11'd576;
            {2'd2, 4'd10}: v = 11'd720;
            {2'd2, 4'd11}: v = 11'd864;
            {2'd2, 4'd12}: v = 11'd1008;
            {2'd2, 4'd13}: v = 11'd1152;
            {2'd2, 4'd14}: v = 11'd1440;
            default:       v = 11'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/mlhd_check.sv =====
// First pipeline stage: header validity checks in priority order and
// extraction of the header fields. Depends on mlhd_pkg.
module mlhd_check
    import mlhd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [HDR_W-1:0]   in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output hdr_fields_t        out_data
);

    logic        valid_reg;
    hdr_fields_t data_reg;
    hdr_fields_t data_next;
    status_t     status_next;

    always_comb
    begin
        priority if (in_word[31:21] != SYNC_CODE)
            status_next = ST_NO_SYNC;
        else if (in_word[20:19] != VERSION_MPEG1)
            status_next = ST_NOT_MPEG1;
        else if (in_word[18:17] == LAYER_CODE_I)
            status_next = ST_LAYER_I;
        else if (in_word[18:17] == LAYER_CODE_II)
            status_next = ST_LAYER_II;
        else if (in_word[18:17] != LAYER_CODE_III)
            status_next = ST_LAYER_RSVD;
        else if (!in_word[16])
            status_next = ST_CRC;
        else if (in_word[15:12] == BR_IDX_BAD)
            status_next = ST_BAD_BITRATE;
        else if (in_word[11:10] == SR_IDX_RSVD)
            status_next = ST_RSVD_RATE;
        else
            status_next = ST_OK;
    end

    always_comb
    begin
        data_next.status = status_next;
        data_next.br_idx = in_word[15:12];
        data_next.sr_idx = in_word[11:10];
        data_next.pad    = in_word[9];
        data_next.mode   = in_word[7:6];
        data_next.ms     = in_word[5];
        data_next.is     = in_word[4];
        data_next.copy   = in_word[3];
        data_next.orig   = in_word[2];
        data_next.emph   = in_word[1:0];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    a_ok_legal_idx: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.status == ST_OK |->
        data_reg.br_idx != BR_IDX_BAD && data_reg.sr_idx != SR_IDX_RSVD)
        else $error("accepted header carries a reserved index");

endmodule

// ===== design/mlhd_lookup.sv =====
// Second pipeline stage: bitrate, sampling rate and unpadded frame length
// taken from the constant tables. Depends on mlhd_pkg.
module mlhd_lookup
    import mlhd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  hdr_fields_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output hdr_lookup_t out_data
);

    logic        valid_reg;
    hdr_lookup_t data_reg;
    hdr_lookup_t data_next;

    always_comb
    begin
        data_next.status   = in_data.status;
        data_next.kbps     = kbps_lookup(in_data.br_idx);
        data_next.rate     = rate_lookup(in_data.sr_idx);
        data_next.base_len = len_lookup(in_data.br_idx, in_data.sr_idx);
        data_next.pad      = in_data.pad;
        data_next.mode     = in_data.mode;
        data_next.ms       = in_data.ms;
        data_next.is       = in_data.is;
        data_next.copy     = in_data.copy;
        data_next.orig     = in_data.orig;
        data_next.emph     = in_data.emph;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    a_free_format_len: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.kbps == 9'd0 |-> data_reg.base_len == 11'd0)
        else $error("free format header has a nonzero base length");

endmodule

// ===== design/mlhd_format.sv =====
// Third pipeline stage: adds the padding byte, masks the stereo flags and
// clears every field but the status of a rejected header. Depends on mlhd_pkg.
module mlhd_format
    import mlhd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  hdr_lookup_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output hdr_result_t out_data
);

    logic        valid_reg;
    hdr_result_t data_reg;
    hdr_result_t data_next;
    logic        ok;
    logic        joint;

    always_comb
    begin
        ok    = (in_data.status == ST_OK);
        joint = (in_data.mode == MODE_JOINT);
        data_next.status           = in_data.status;
        data_next.frame_length     = ok ? in_data.base_len + {10'd0, in_data.pad} : 11'd0;
        data_next.bitrate_kbps     = ok ? in_data.kbps : 9'd0;
        data_next.sample_rate_hz   = ok ? in_data.rate : 16'd0;
        data_next.padded           = ok & in_data.pad;
        data_next.channel_mode     = ok ? in_data.mode : 2'd0;
        data_next.intensity_stereo = ok & joint & in_data.is;
        data_next.mid_side_stereo  = ok & joint & in_data.ms;
        data_next.copyright_flag   = ok & in_data.copy;
        data_next.original_flag    = ok & in_data.orig;
        data_next.emphasis         = ok ? in_data.emph : 2'd0;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    a_stereo_flags: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.channel_mode != MODE_JOINT |->
        !data_reg.intensity_stereo && !data_reg.mid_side_stereo)
        else $error("stereo flags set outside joint stereo");

endmodule

// ===== design/mpeg1_layer3_header_decoder.sv =====
// Top level of the MPEG-1 layer III header decoder: three-stage pipeline of
// check, table lookup and output formatting. Depends on mlhd_pkg and the
// mlhd_check, mlhd_lookup and mlhd_format stages.
//
//  Channel  Direction  Width  Contents
//  s_*      in         32     one header word per item
//  m_*      out        56     status and decoded fields per item
//
// Each item passes through the check, lookup and format registers in order,
// and one item can enter in every cycle while m_tready is high.
// Reset empties every stage. A stall on m_tready holds each full stage and
// backs up to s_tready only once all three stages are full.
module mpeg1_layer3_header_decoder
    import mlhd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [HDR_W-1:0] s_tdata,   // [31:0] header_word
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [RES_W-1:0] m_tdata    // [3:0] status, [14:4] frame_length,
                                        // [23:15] bitrate_kbps,
                                        // [39:24] sample_rate_hz, [40] padded,
                                        // [42:41] channel_mode,
                                        // [43] intensity_stereo,
                                        // [44] mid_side_stereo,
                                        // [45] copyright_flag,
                                        // [46] original_flag, [48:47] emphasis
);

    hdr_fields_t fields;
    hdr_lookup_t looked;
    hdr_result_t result;
    logic        v1;
    logic        r1;
    logic        v2;
    logic        r2;

    mlhd_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (s_tdata),
        .out_valid (v1),
        .out_ready (r1),
        .out_data  (fields)
    );

    mlhd_lookup u_lookup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_data   (fields),
        .out_valid (v2),
        .out_ready (r2),
        .out_data  (looked)
    );

    mlhd_format u_format (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .in_ready  (r2),
        .in_data   (looked),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tdata = {7'd0,
                      result.emphasis,
                      result.original_flag,
                      result.copyright_flag,
                      result.mid_side_stereo,
                      result.intensity_stereo,
                      result.channel_mode,
                      result.padded,
                      result.sample_rate_hz,
                      result.bitrate_kbps,
                      result.frame_length,
                      result.status};

    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while the output side is ready");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && result.status != ST_OK |->
        result.frame_length == 11'd0 && result.sample_rate_hz == 16'd0)
        else $error("rejected header carries decoded fields");

endmodule
